[sv/hfve_pkg.sv]
package hfve_pkg;

   localparam int NameMaxDefault    = 16;
   localparam int LengthBitsDefault = 16;

   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = 64;

   // register indexes on the csr port
   localparam logic [CsrIndexBits-1:0] CSR_NAME_LOW   = 3'd0;
   localparam logic [CsrIndexBits-1:0] CSR_NAME_HIGH  = 3'd1;
   localparam logic [CsrIndexBits-1:0] CSR_NAME_LEN   = 3'd2;
   localparam logic [CsrIndexBits-1:0] CSR_COPY_LIMIT = 3'd3;
   localparam logic [CsrIndexBits-1:0] CSR_BARE_LF    = 3'd4;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_NO_COLON  = 2'd2;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic        is_final;
      logic [7:0]  data_byte;
      logic [1:0]  status;
      logic [15:0] value_length;
   } rsp_type;

endpackage

[sv/header_field_value_extractor.sv]
// channel  | direction | handshake               | beat
// ---------+-----------+-------------------------+---------------------------------
// req_     | in        | req_valid / req_stall   | one message byte + end marker
// rsp_     | out       | rsp_valid / rsp_stall   | one value byte or final status
// csr_     | in        | csr_write_enable        | one register write, no read-back
//
// One byte is taken per cycle while req_stall is low; its state update and results are settled in that
// same cycle and written into a four-entry result queue, which drives rsp_ directly.
// A byte can yield two results (last value byte plus final status), so req_stall
// is high while fewer than two queue slots are free; the queue alone sets the rate.
// Reset (synchronous) empties the queue, returns to line start and loads register
// defaults. A stalled rsp_ beat holds until taken.
module header_field_value_extractor
   #(
      parameter int NAME_MAX    = hfve_pkg::NameMaxDefault,
      parameter int LENGTH_BITS = hfve_pkg::LengthBitsDefault
   )
   (
      input  logic                                 clock,
      input  logic                                 reset,
      input  logic                                 req_valid,
      output logic                                 req_stall,
      input  hfve_pkg::req_type                    req_data,
      output logic                                 rsp_valid,
      input  logic                                 rsp_stall,
      output hfve_pkg::rsp_type                    rsp_data,
      input  logic                                 csr_write_enable,
      input  logic [hfve_pkg::CsrIndexBits-1:0]    csr_index,
      input  logic [hfve_pkg::CsrDataBits-1:0]     csr_wdata
   );

   import hfve_pkg::*;

   localparam int PosBits = $clog2(NAME_MAX + 1);
   localparam int CmpBits = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
   localparam int QDepth  = 4;
   localparam int QPtrBits = $clog2(QDepth);
   localparam int QCntBits = $clog2(QDepth + 1);
   localparam logic [LENGTH_BITS-1:0] CountMax = '1;

   typedef enum logic [2:0] {
      PH_LINE_START,
      PH_SKIP_LINE,
      PH_SEEK_COLON,
      PH_LWS,
      PH_LWS_CR,
      PH_LWS_NL,
      PH_VALUE,
      PH_DONE
   } phase_type;

   logic [63:0]             name_low_ff;
   logic [63:0]             name_high_ff;
   logic [4:0]              name_len_ff;
   logic [15:0]             copy_limit_ff;
   logic                    bare_lf_ff;

   phase_type               phase_ff, phase_in;
   logic [PosBits-1:0]      pos_ff, pos_in;
   logic [LENGTH_BITS-1:0]  cnt_ff, cnt_in;

   rsp_type                 queue_ff [QDepth];
   logic [QPtrBits-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPtrBits-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QCntBits-1:0]     count_ff, count_in;

   logic                    req_accept;
   logic                    rsp_accept;
   logic [PosBits-1:0]      len_eff;
   logic [127:0]            name_bytes;
   logic [3:0]              name_idx;
   logic [7:0]              name_cur;
   logic [7:0]              b;
   logic                    ws;
   rsp_type                 res0, res1;
   logic [1:0]              res_count;

   function automatic logic [1:0] end_status(phase_type ph);
      logic [1:0] st;
      if (ph == PH_LINE_START || ph == PH_SKIP_LINE) begin
         st = ST_NOT_FOUND;
      end else if (ph == PH_SEEK_COLON) begin
         st = ST_NO_COLON;
      end else begin
         st = ST_FOUND;
      end
      return st;
   endfunction

   function automatic rsp_type final_rsp(logic [1:0] st, logic [LENGTH_BITS-1:0] cnt);
      rsp_type r;
      r.is_final     = 1'b1;
      r.data_byte    = 8'd0;
      r.status       = st;
      r.value_length = (st == ST_FOUND) ? 16'(cnt) : 16'd0;
      return r;
   endfunction

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = count_ff > QCntBits'(QDepth - 2);
   assign rsp_valid  = count_ff != '0;
   assign rsp_data   = queue_ff[rd_ptr_ff];

   assign len_eff    = (name_len_ff > 5'(NAME_MAX)) ? PosBits'(NAME_MAX)
                                                    : PosBits'(name_len_ff);
   assign name_bytes = {name_high_ff, name_low_ff};
   assign name_idx   = 4'(pos_ff);
   assign name_cur   = name_bytes[{name_idx, 3'b000} +: 8];
   assign b          = req_data.msg_byte;
   assign ws         = (b == CHAR_SPACE) || (b == CHAR_TAB);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      res0      = '0;
      res1      = '0;
      res_count = 2'd0;

      if (phase_ff != PH_DONE) begin
         // empty or shrunken name: already matched
         if (phase_in == PH_LINE_START && pos_ff >= len_eff) begin
            phase_in = PH_SEEK_COLON;
         end

         if (b == CHAR_NUL) begin
            res0      = final_rsp(end_status(phase_in), cnt_ff);
            res_count = 2'd1;
            phase_in  = PH_DONE;
         end else begin
            unique case (phase_in)
               PH_LINE_START: begin
                  if (b == name_cur) begin
                     pos_in = pos_ff + PosBits'(1);
                     if (pos_in >= len_eff) begin
                        phase_in = PH_SEEK_COLON;
                     end
                  end else if (b == CHAR_LF) begin
                     pos_in = '0;
                  end else begin
                     phase_in = PH_SKIP_LINE;
                  end
               end
               PH_SKIP_LINE: begin
                  if (b == CHAR_LF) begin
                     phase_in = PH_LINE_START;
                     pos_in   = '0;
                  end
               end
               PH_SEEK_COLON: begin
                  if (b == CHAR_COLON) begin
                     phase_in = PH_LWS;
                  end
               end
               PH_LWS: begin
                  if (ws) begin
                     phase_in = PH_LWS;
                  end else if (b == CHAR_CR) begin
                     phase_in = PH_LWS_CR;
                  end else if (b == CHAR_LF) begin
                     if (bare_lf_ff) begin
                        phase_in = PH_LWS_NL;
                     end else begin
                        res0      = final_rsp(ST_FOUND, cnt_ff);
                        res_count = 2'd1;
                        phase_in  = PH_DONE;
                     end
                  end else begin
                     phase_in = PH_VALUE;
                  end
               end
               PH_LWS_CR: begin
                  if (b == CHAR_LF) begin
                     phase_in = PH_LWS_NL;
                  end else begin
                     res0      = final_rsp(ST_FOUND, cnt_ff);
                     res_count = 2'd1;
                     phase_in  = PH_DONE;
                  end
               end
               PH_LWS_NL: begin
                  if (ws) begin
                     phase_in = PH_LWS;
                  end else begin
                     res0      = final_rsp(ST_FOUND, cnt_ff);
                     res_count = 2'd1;
                     phase_in  = PH_DONE;
                  end
               end
               PH_VALUE: begin
                  if (b == CHAR_CR || b == CHAR_LF) begin
                     res0      = final_rsp(ST_FOUND, cnt_ff);
                     res_count = 2'd1;
                     phase_in  = PH_DONE;
                  end
               end
               PH_DONE: begin
                  phase_in = PH_DONE;
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase

            // copy the value byte, count saturates
            if (phase_in == PH_VALUE && b != CHAR_CR && b != CHAR_LF) begin
               if (CmpBits'(cnt_ff) < CmpBits'(copy_limit_ff) && cnt_ff != CountMax) begin
                  res0.is_final     = 1'b0;
                  res0.data_byte    = b;
                  res0.status       = ST_FOUND;
                  res0.value_length = 16'd0;
                  res_count         = 2'd1;
               end
               if (cnt_ff != CountMax) begin
                  cnt_in = cnt_ff + LENGTH_BITS'(1);
               end
            end

            if (req_data.end_of_message && phase_in != PH_DONE) begin
               if (res_count == 2'd0) begin
                  res0 = final_rsp(end_status(phase_in), cnt_in);
               end else begin
                  res1 = final_rsp(end_status(phase_in), cnt_in);
               end
               res_count = res_count + 2'd1;
            end
         end
      end

      if (req_data.end_of_message) begin
         phase_in = PH_LINE_START;
         pos_in   = '0;
         cnt_in   = '0;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_accept) begin
         wr_ptr_in = wr_ptr_ff + QPtrBits'(res_count);
         count_in  = count_in + QCntBits'(res_count);
      end
      if (rsp_accept) begin
         rd_ptr_in = rd_ptr_ff + QPtrBits'(1);
         count_in  = count_in - QCntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_low_ff   <= '0;
         name_high_ff  <= '0;
         name_len_ff   <= 5'd1;
         copy_limit_ff <= '0;
         bare_lf_ff    <= 1'b0;
         phase_ff      <= PH_LINE_START;
         pos_ff        <= '0;
         cnt_ff        <= '0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_NAME_LOW:   name_low_ff   <= csr_wdata;
               CSR_NAME_HIGH:  name_high_ff  <= csr_wdata;
               CSR_NAME_LEN:   name_len_ff   <= csr_wdata[4:0];
               CSR_COPY_LIMIT: copy_limit_ff <= csr_wdata[15:0];
               CSR_BARE_LF:    bare_lf_ff    <= csr_wdata[0];
               default:        ;
            endcase
         end
         if (req_accept) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            cnt_ff   <= cnt_in;
         end
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && res_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (req_accept && res_count == 2'd2) begin
         queue_ff[wr_ptr_ff + QPtrBits'(1)] <= res1;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCntBits'(QDepth))
      else $error("result queue overflow");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      QPtrBits'(wr_ptr_ff - rd_ptr_ff) == QPtrBits'(count_ff))
      else $error("queue pointers disagree with fill count");

   a_eom_fresh: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.end_of_message |=>
         phase_ff == PH_LINE_START && pos_ff == '0 && cnt_ff == '0)
      else $error("state not cleared after end of message");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_final |->
         rsp_data.status == ST_FOUND && rsp_data.value_length == 16'd0)
      else $error("data beat carries status fields");

   a_miss_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_final && rsp_data.status != ST_FOUND |->
         rsp_data.value_length == 16'd0 && rsp_data.data_byte == 8'd0)
      else $error("miss status with nonzero length");

endmodule

[sim/extractor_checker.sv]
module extractor_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  hfve_pkg::req_type                 req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  hfve_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write_enable,
   input  logic [hfve_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [hfve_pkg::CsrDataBits-1:0]  csr_wdata,
   output int                                mismatch_count,
   output int                                pending_results,
   output int                                parsed_bytes,
   output int                                value_beats,
   output int                                status_beats
);
   timeunit 1ns;
   timeprecision 1ps;
   import hfve_pkg::*;

   localparam int unsigned NAME_LIMIT = NameMaxDefault;
   localparam longint unsigned COUNT_TOP = (64'd1 << LengthBitsDefault) - 64'd1;
   localparam int REPORT_LIMIT = 20;

   typedef enum logic [2:0] {
      AT_LINE_START,
      SKIPPING_LINE,
      SEEKING_COLON,
      SKIPPING_WS,
      WS_AFTER_CR,
      WS_AFTER_NL,
      IN_VALUE,
      FINISHED
   } parse_phase_type;

   logic [63:0] name_low;
   logic [63:0] name_high;
   logic [4:0]  name_len;
   logic [15:0] copy_lim;
   logic        bare_lf;

   parse_phase_type stage;
   int unsigned     name_pos;
   longint unsigned value_count;

   rsp_type extract_results_due [$];

   function automatic void restart();
      stage = AT_LINE_START;
      name_pos = 0;
      value_count = 0;
   endfunction

   function automatic logic [7:0] name_char(int unsigned pos);
      logic [63:0] word;
      word = ((pos % 16) < 8) ? name_low : name_high;
      return word[(pos % 8) * 8 +: 8];
   endfunction

   function automatic logic [1:0] status_at_end();
      if (stage == AT_LINE_START || stage == SKIPPING_LINE) return ST_NOT_FOUND;
      if (stage == SEEKING_COLON) return ST_NO_COLON;
      return ST_FOUND;
   endfunction

   function automatic void queue_status(logic [1:0] st);
      rsp_type beat;
      beat = '0;
      beat.is_final = 1'b1;
      beat.status = st;
      beat.value_length = (st == ST_FOUND) ? value_count[15:0] : 16'd0;
      extract_results_due.push_back(beat);
   endfunction

   function automatic void queue_value(logic [7:0] b);
      rsp_type beat;
      beat = '0;
      beat.data_byte = b;
      extract_results_due.push_back(beat);
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic eom);
      logic        ws;
      int unsigned used;
      ws = (b == CHAR_SPACE) || (b == CHAR_TAB);
      used = (name_len > NAME_LIMIT) ? NAME_LIMIT : name_len;
      if (stage == FINISHED) begin
         // drop bytes after the final status until the message ends
         if (eom) restart();
      end else begin
         parsed_bytes++;
         if (stage == AT_LINE_START && name_pos >= used) stage = SEEKING_COLON;
         if (b == CHAR_NUL) begin
            queue_status(status_at_end());
            stage = FINISHED;
            if (eom) restart();
         end else begin
            case (stage)
               AT_LINE_START: begin
                  if (b == name_char(name_pos)) begin
                     name_pos++;
                     if (name_pos >= used) stage = SEEKING_COLON;
                  end else if (b == CHAR_LF) begin
                     name_pos = 0;
                  end else begin
                     stage = SKIPPING_LINE;
                  end
               end
               SKIPPING_LINE: begin
                  if (b == CHAR_LF) begin
                     stage = AT_LINE_START;
                     name_pos = 0;
                  end
               end
               SEEKING_COLON: begin
                  if (b == CHAR_COLON) stage = SKIPPING_WS;
               end
               SKIPPING_WS: begin
                  if (!ws) begin
                     if (b == CHAR_CR) begin
                        stage = WS_AFTER_CR;
                     end else if (b == CHAR_LF) begin
                        if (bare_lf) begin
                           stage = WS_AFTER_NL;
                        end else begin
                           queue_status(ST_FOUND);
                           stage = FINISHED;
                        end
                     end else begin
                        stage = IN_VALUE;
                     end
                  end
               end
               WS_AFTER_CR: begin
                  if (b == CHAR_LF) begin
                     stage = WS_AFTER_NL;
                  end else begin
                     queue_status(ST_FOUND);
                     stage = FINISHED;
                  end
               end
               WS_AFTER_NL: begin
                  if (ws) begin
                     stage = SKIPPING_WS;
                  end else begin
                     queue_status(ST_FOUND);
                     stage = FINISHED;
                  end
               end
               IN_VALUE: begin
                  if (b == CHAR_CR || b == CHAR_LF) begin
                     queue_status(ST_FOUND);
                     stage = FINISHED;
                  end
               end
               default: begin
               end
            endcase
            if (stage == IN_VALUE && b != CHAR_CR && b != CHAR_LF) begin
               // copy only below the limit, and stop counting at saturation
               if (value_count < copy_lim && value_count < COUNT_TOP) queue_value(b);
               if (value_count < COUNT_TOP) value_count++;
            end
            if (eom) begin
               if (stage != FINISHED) queue_status(status_at_end());
               restart();
            end
         end
      end
   endtask

   task automatic compare_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (extract_results_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result beat with nothing due: final %0b data %h status %0d length %0d",
                     $time, got.is_final, got.data_byte, got.status, got.value_length);
      end else begin
         want = extract_results_due.pop_front();
         compare_field("is_final", 16'(want.is_final), 16'(got.is_final));
         compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
         compare_field("status", 16'(want.status), 16'(got.status));
         compare_field("value_length", want.value_length, got.value_length);
         if (want.is_final) status_beats++;
         else value_beats++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         name_low = '0;
         name_high = '0;
         name_len = 5'd1;
         copy_lim = '0;
         bare_lf = 1'b0;
         restart();
         extract_results_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_beat(rsp_data);
         if (req_valid && !req_stall) parse_byte(req_data.msg_byte, req_data.end_of_message);
         // register writes apply from the next byte on
         if (csr_write_enable) begin
            case (csr_index)
               CSR_NAME_LOW:   name_low = csr_wdata;
               CSR_NAME_HIGH:  name_high = csr_wdata;
               CSR_NAME_LEN:   name_len = csr_wdata[4:0];
               CSR_COPY_LIMIT: copy_lim = csr_wdata[15:0];
               CSR_BARE_LF:    bare_lf = csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      pending_results = extract_results_due.size();
   end

endmodule

[sim/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hfve_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_write_enable = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CsrDataBits-1:0]  csr_wdata = '0;

   int fail_count;
   int pending_results;
   int parsed_bytes;
   int value_beats;
   int status_beats;
   int cycle_count = 0;
   int send_gap_pct = 0;
   int rsp_hold_pct = 0;

   logic [7:0] name_chars [16];
   int         name_used = 1;
   logic [7:0] msg_bytes [$];

   header_field_value_extractor uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   extractor_checker monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (fail_count),
      .pending_results  (pending_results),
      .parsed_bytes     (parsed_bytes),
      .value_beats      (value_beats),
      .status_beats     (status_beats)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_hold_pct);
      cycle_count++;
   end

   initial begin
      wait (cycle_count > CYCLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic eom);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {b, eom};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_message();
      int i;
      for (i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
   endtask

   // hold off the sender until every predicted beat has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CsrIndexBits-1:0] idx, input logic [63:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic write_setup(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input logic [15:0] lim,
                              input logic bare_lf);
      int i;
      settle();
      put_reg(CSR_NAME_LOW, lo);
      put_reg(CSR_NAME_HIGH, hi);
      put_reg(CSR_NAME_LEN, 64'(len));
      put_reg(CSR_COPY_LIMIT, 64'(lim));
      put_reg(CSR_BARE_LF, 64'(bare_lf));
      csr_write_enable <= 1'b0;
      for (i = 0; i < 8; i++) begin
         name_chars[i] = lo[i*8 +: 8];
         name_chars[i+8] = hi[i*8 +: 8];
      end
      name_used = (len > 16) ? 16 : len;
   endtask

   // mostly a small alphabet so that partial name matches happen often
   function automatic logic [7:0] pick_text_char();
      case ($urandom_range(5))
         0: return "a";
         1: return "B";
         2: return "-";
         3: return "x";
         default: return 8'($urandom_range(126, 33));
      endcase
   endfunction

   function automatic void end_line();
      if ($urandom_range(3) == 0) begin
         msg_bytes.push_back(CHAR_LF);
      end else begin
         msg_bytes.push_back(CHAR_CR);
         msg_bytes.push_back(CHAR_LF);
      end
   endfunction

   function automatic void add_other_line();
      repeat ($urandom_range(3, 1)) msg_bytes.push_back(pick_text_char());
      msg_bytes.push_back(CHAR_COLON);
      msg_bytes.push_back(CHAR_SPACE);
      repeat ($urandom_range(3)) msg_bytes.push_back(pick_text_char());
      end_line();
   endfunction

   task automatic run_random_round(input int gap_pct, input int hold_pct, input int bytes_wanted);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  len;
      logic [15:0] lim;
      logic [7:0]  c;
      int          goal;
      int          r;
      int          cut;
      int          i;
      send_gap_pct = gap_pct;
      rsp_hold_pct = hold_pct;
      goal = parsed_bytes + bytes_wanted;
      while (parsed_bytes < goal) begin
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
         r = $urandom_range(99);
         if (r < 5) len = 5'd0;
         else if (r < 10) len = 5'($urandom_range(31, 17));
         else if (r < 18) len = 5'd16;
         else len = 5'($urandom_range(4, 1));
         for (i = 0; i < 16 && i < len; i++) begin
            r = $urandom_range(99);
            c = pick_text_char();
            if (r >= 90) begin
               case (r)
                  90, 91, 92: c = CHAR_COLON;
                  93, 94:     c = CHAR_LF;
                  95, 96:     c = CHAR_NUL;
                  97:         c = CHAR_CR;
                  default:    c = 8'hff;
               endcase
            end
            if (i < 8) lo[i*8 +: 8] = c;
            else hi[(i-8)*8 +: 8] = c;
         end
         r = $urandom_range(99);
         if (r < 15) lim = 16'd0;
         else if (r < 25) lim = 16'hffff;
         else if (r < 35) lim = 16'($urandom_range(65535));
         else lim = 16'($urandom_range(6, 1));
         write_setup(lo, hi, len, lim, 1'($urandom_range(1)));

         repeat ($urandom_range(8, 3)) begin
            msg_bytes.delete();
            if ($urandom_range(99) < 12) begin
               repeat ($urandom_range(10, 1)) msg_bytes.push_back(8'($urandom_range(255)));
            end else begin
               repeat ($urandom_range(2)) add_other_line();
               cut = ($urandom_range(9) == 0) ? $urandom_range(name_used) : name_used;
               for (i = 0; i < cut; i++) msg_bytes.push_back(name_chars[i]);
               if (cut < name_used || $urandom_range(4) == 0) msg_bytes.push_back(pick_text_char());
               // sometimes put the colon on a later line, or leave it out
               if ($urandom_range(9) == 0) end_line();
               if ($urandom_range(9) != 0) msg_bytes.push_back(CHAR_COLON);
               repeat ($urandom_range(3)) begin
                  case ($urandom_range(3))
                     0: msg_bytes.push_back(CHAR_SPACE);
                     1: msg_bytes.push_back(CHAR_TAB);
                     2: begin
                        msg_bytes.push_back(CHAR_CR);
                        msg_bytes.push_back(CHAR_LF);
                        msg_bytes.push_back(CHAR_SPACE);
                     end
                     default: begin
                        msg_bytes.push_back(CHAR_LF);
                        msg_bytes.push_back(CHAR_TAB);
                     end
                  endcase
               end
               repeat ($urandom_range(6)) begin
                  c = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 1))
                                               : 8'($urandom_range(126, 32));
                  if (c == CHAR_CR || c == CHAR_LF) c = "v";
                  msg_bytes.push_back(c);
               end
               case ($urandom_range(9))
                  0, 1, 2, 3: begin
                     msg_bytes.push_back(CHAR_CR);
                     msg_bytes.push_back(CHAR_LF);
                  end
                  4, 5: msg_bytes.push_back(CHAR_LF);
                  6: begin
                     msg_bytes.push_back(CHAR_CR);
                     msg_bytes.push_back(pick_text_char());
                  end
                  7: msg_bytes.push_back(CHAR_NUL);
                  default: begin
                  end
               endcase
               if ($urandom_range(3) == 0) add_other_line();
            end
            // truncate now and then so the message ends mid-field
            if ($urandom_range(11) == 0)
               repeat ($urandom_range(3, 1))
                  if (msg_bytes.size() > 1) void'(msg_bytes.pop_back());
            if (msg_bytes.size() == 0) msg_bytes.push_back("x");
            send_message();
            if ($urandom_range(39) == 0) settle();
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 15;
      rsp_hold_pct = 74;

      // reset setting: the name is one zero byte, so it never matches
      msg_bytes = {8'hff};
      send_message();

      write_setup(64'h6f48, '1, 5'd2, 16'd1, 1'b1);
      // bare LF fold, copy limit cuts the value, CR closes it on the last beat
      msg_bytes = {"H", "o", CHAR_COLON, CHAR_SPACE, CHAR_LF, CHAR_SPACE, "z", "q", CHAR_CR};
      send_message();
      // zero byte before any colon, then a byte dropped up to the end marker
      msg_bytes = {CHAR_LF, "H", "o", CHAR_NUL, "Z"};
      send_message();

      write_setup('0, '0, 5'd0, 16'd0, 1'b0);
      // empty name matches at once; lone LF is not folded here
      msg_bytes = {CHAR_COLON, CHAR_LF};
      send_message();
      msg_bytes = {"a", CHAR_COLON, "b"};
      send_message();
      // CR not followed by LF leaves the value empty
      msg_bytes = {CHAR_COLON, CHAR_CR, "x"};
      send_message();

      run_random_round(15, 74, 170);
      run_random_round(74, 15, 170);
      run_random_round(0, 0, 170);
      settle();

      $display("Parsed %0d bytes, checked %0d value beats and %0d status beats in %0d cycles,",
               parsed_bytes, value_beats, status_beats, cycle_count);
      $display("over name lengths 0 to 31, copy limits 0 to 65535 and both line-break modes.");
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
sv/hfve_pkg.sv
sv/header_field_value_extractor.sv
sim/extractor_checker.sv
sim/tb.sv
